// ----- design/btb_pkg.sv -----
// Shared constants and types for the BTB / bimodal branch predictor.
// No dependencies.
package btb_pkg;
   localparam int unsigned BtbSetsDefault    = 64;
   localparam int unsigned BtbWaysDefault    = 4;
   localparam int unsigned BhtEntriesDefault = 1024;
   localparam int unsigned InstBytesDefault  = 4;
   localparam int unsigned PcWidth           = 64;
   localparam int unsigned SlotWidth         = 4;
   localparam int unsigned FwWidth           = 5;
   localparam logic [FwWidth-1:0] FetchWidthReset = 5'd8;
   localparam logic [1:0] CtrReset = 2'd1;
   localparam logic [1:0] CtrMax   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CLEAR
   } state_type;

   typedef enum logic {
      ACT_PREDICT = 1'b0,
      ACT_UPDATE  = 1'b1
   } action_type;
endpackage

// ----- design/btb_bimodal_branch_predictor.sv -----
// Top level: BTB with true-LRU replacement plus bimodal direction counters.
// Depends on btb_pkg, btb_ctr_table, btb_way_table.
//
//  channel | dir | fields
//  req     | in  | tuser=action, tdata={target_pc,taken,slot,pc}
//  rsp     | out | tdata={pred_taken,btb_hit,next_pc,pred_slot}
//  csr     | in  | wdata=fetch_width
//
// Each beat reads counter and set row synchronously on accept, then modifies and
// writes them back in ST_LOOKUP while the result is registered for rsp.
// A new beat is taken only once the last result has left rsp; a stalled rsp holds it.
// After reset a clearing pass walks the counter and set addresses, writing
// counters to weakly not-taken and LRU/valid rows to reset; req is held off.
module btb_bimodal_branch_predictor #(
   parameter int unsigned BTB_SETS    = btb_pkg::BtbSetsDefault,
   parameter int unsigned NUM_WAYS    = btb_pkg::BtbWaysDefault,
   parameter int unsigned CTR_ENTRIES = btb_pkg::BhtEntriesDefault,
   parameter int unsigned INST_BYTES  = btb_pkg::InstBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] pc, [67:64] slot, [68] taken, [132:69] target_pc
   input  logic [135:0] req_tdata,
   // [0] action
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [4:0] pred_slot, [68:5] next_pc, [69] btb_hit, [70] pred_taken
   output logic [71:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [btb_pkg::FwWidth-1:0] csr_wdata
);
   import btb_pkg::*;

   localparam int unsigned SetBits  = (BTB_SETS > 1) ? $clog2(BTB_SETS) : 1;
   localparam int unsigned SetShift = $clog2(BTB_SETS);
   localparam int unsigned CtrBits  = $clog2(CTR_ENTRIES);
   localparam int unsigned WayBits  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int unsigned TagBits  = PcWidth - 1 - SetShift;
   localparam int unsigned EntBits  = 1 + TagBits + SlotWidth + PcWidth;
   localparam int unsigned LruBits  = NUM_WAYS * WayBits;
   localparam int unsigned RowBits  = NUM_WAYS * EntBits + LruBits;
   localparam int unsigned ClrLen   = (CTR_ENTRIES > BTB_SETS) ? CTR_ENTRIES : BTB_SETS;
   localparam int unsigned ClrBits  = $clog2(ClrLen + 1);

   typedef struct packed {
      logic                 valid;
      logic [TagBits-1:0]   tag;
      logic [SlotWidth-1:0] slot;
      logic [PcWidth-1:0]   target;
   } entry_type;

   state_type state_ff, state_in;
   logic [ClrBits-1:0] clr_ff, clr_in;
   logic [FwWidth-1:0] fw_ff;
   logic               act_ff;
   logic [PcWidth-1:0] pc_ff, tgt_ff;
   logic [SlotWidth-1:0] slot_ff;
   logic               taken_ff;
   logic               out_vld_ff, out_vld_in;
   logic [71:0]        out_data_ff, out_data_in;

   logic               rd_en;
   logic [1:0]         ctr_rd, ctr_wd;
   logic               ctr_we;
   logic [CtrBits-1:0] ctr_ra, ctr_wa;
   logic [RowBits-1:0] row_rd, row_wd;
   logic               row_we;
   logic [SetBits-1:0] row_ra, row_wa;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE) && !out_vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = accept;
   assign ctr_ra     = req_tdata[CtrBits:1];
   assign row_ra     = SetBits'(req_tdata[63:1] & 63'(BTB_SETS - 1));

   btb_ctr_table #(.CTR_ENTRIES(CTR_ENTRIES)) u_ctr (
      .clock(clock), .rd_en(rd_en), .rd_addr(ctr_ra), .rd_data(ctr_rd),
      .wr_en(ctr_we), .wr_addr(ctr_wa), .wr_data(ctr_wd)
   );

   btb_way_table #(.BTB_SETS(BTB_SETS), .ROW_BITS(RowBits)) u_way (
      .clock(clock), .rd_en(rd_en), .rd_addr(row_ra), .rd_data(row_rd),
      .wr_en(row_we), .wr_addr(row_wa), .wr_data(row_wd)
   );

   // Lookup/modify for the held beat
   entry_type             ents [NUM_WAYS];
   logic [WayBits-1:0]    lru [NUM_WAYS];
   logic [TagBits-1:0]    tag;
   logic [SetBits-1:0]    set_idx;
   logic                  hit, pt, ut;
   logic [WayBits-1:0]    hway, vway, uway;
   logic [1:0]            ctr_new;
   logic [PcWidth-1:0]    fall, resolved;

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         ents[w] = row_rd[w*EntBits +: EntBits];
         lru[w]  = row_rd[NUM_WAYS*EntBits + w*WayBits +: WayBits];
      end
      tag     = pc_ff[PcWidth-1:1+SetShift];
      set_idx = SetBits'(pc_ff[63:1] & 63'(BTB_SETS - 1));
      hit = 1'b0;
      hway = '0;
      vway = lru[NUM_WAYS-1];
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (ents[w].valid && ents[w].tag == tag) begin
            hit = 1'b1;
            hway = WayBits'(w);
         end
         if (!ents[w].valid) begin
            vway = WayBits'(w);
         end
      end
      pt = ctr_rd >= 2'd2;
      if (taken_ff) begin
         ctr_new = (ctr_rd == CtrMax) ? CtrMax : ctr_rd + 2'd1;
      end else begin
         ctr_new = (ctr_rd == 2'd0) ? 2'd0 : ctr_rd - 2'd1;
      end
      ut = ctr_new >= 2'd2;
      fall = pc_ff + PcWidth'(slot_ff) + PcWidth'(INST_BYTES);
      resolved = taken_ff ? tgt_ff : fall;
      uway = hit ? hway : vway;
   end

   // Row rewrite: entries and move-to-front of the touched way
   logic [RowBits-1:0] row_mod;
   logic [WayBits-1:0] mru_way;
   logic               seen;
   always_comb begin
      row_mod = row_rd;
      mru_way = (act_ff == ACT_UPDATE) ? uway : hway;
      if (act_ff == ACT_UPDATE) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (WayBits'(w) == uway) begin
               if (hit) begin
                  row_mod[w*EntBits +: EntBits] = {1'b1, ents[w].tag, slot_ff,
                     taken_ff ? tgt_ff : ents[w].target};
               end else begin
                  row_mod[w*EntBits +: EntBits] = {1'b1, tag, slot_ff, resolved};
               end
            end
         end
      end
      seen = 1'b0;
      for (int p = NUM_WAYS - 1; p >= 1; p--) begin
         if (lru[p] == mru_way) begin
            seen = 1'b1;
         end
         if (seen || p == 0) begin
            row_mod[NUM_WAYS*EntBits + p*WayBits +: WayBits] = lru[p-1];
         end
      end
      row_mod[NUM_WAYS*EntBits +: WayBits] = mru_way;
   end

   logic [RowBits-1:0] row_reset;
   always_comb begin
      row_reset = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_reset[NUM_WAYS*EntBits + w*WayBits +: WayBits] = WayBits'(w);
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ClrBits'(ClrLen - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctr_we = 1'b0;
      ctr_wa = pc_ff[CtrBits:1];
      ctr_wd = ctr_new;
      row_we = 1'b0;
      row_wa = set_idx;
      row_wd = row_mod;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_data_in = out_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ctr_we = (clr_ff < ClrBits'(CTR_ENTRIES));
            ctr_wa = clr_ff[CtrBits-1:0];
            ctr_wd = CtrReset;
            row_we = (clr_ff < ClrBits'(BTB_SETS));
            row_wa = clr_ff[SetBits-1:0];
            row_wd = row_reset;
         end
         ST_LOOKUP: begin
            out_vld_in = 1'b1;
            if (act_ff == ACT_UPDATE) begin
               ctr_we = 1'b1;
               row_we = 1'b1;
               out_data_in = {1'b0, ut, hit, resolved, 1'b0, slot_ff};
            end else begin
               row_we = hit;
               if (hit) begin
                  out_data_in = {1'b0, pt, 1'b1,
                     pt ? ents[hway].target
                        : pc_ff + PcWidth'(ents[hway].slot) + PcWidth'(INST_BYTES),
                     1'b0, ents[hway].slot};
               end else begin
                  out_data_in = {1'b0, pt, 1'b0,
                     pc_ff + PcWidth'(fw_ff) * PcWidth'(INST_BYTES), fw_ff};
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         out_vld_ff <= 1'b0;
         fw_ff      <= FetchWidthReset;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         out_vld_ff <= out_vld_in;
         if (csr_wen) begin
            fw_ff <= csr_wdata;
         end
      end
      out_data_ff <= out_data_in;
      if (accept) begin
         act_ff   <= req_tuser;
         pc_ff    <= req_tdata[63:0];
         slot_ff  <= req_tdata[67:64];
         taken_ff <= req_tdata[68];
         tgt_ff   <= req_tdata[132:69];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |-> !req_tready) else $error("accept while busy");
   a_lookup_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> rsp_tvalid) else $error("result lost");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule

// ----- design/btb_ctr_table.sv -----
// Direction counter table: 2-bit saturating counters in one synchronous memory.
// Depends on btb_pkg.
module btb_ctr_table #(
   parameter int unsigned CTR_ENTRIES = btb_pkg::BhtEntriesDefault
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [$clog2(CTR_ENTRIES)-1:0] rd_addr,
   output logic [1:0]                     rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(CTR_ENTRIES)-1:0] wr_addr,
   input  logic [1:0]                     wr_data
);
   import btb_pkg::*;

   logic [1:0] mem [CTR_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- design/btb_way_table.sv -----
// BTB set memory: one row per set holding valid, tag, slot and target for each way plus the LRU order.
// Depends on btb_pkg.
module btb_way_table #(
   parameter int unsigned BTB_SETS = btb_pkg::BtbSetsDefault,
   parameter int unsigned ROW_BITS = 8
) (
   input  logic                                           clock,
   input  logic                                           rd_en,
   input  logic [(BTB_SETS > 1 ? $clog2(BTB_SETS) : 1)-1:0] rd_addr,
   output logic [ROW_BITS-1:0]                            rd_data,
   input  logic                                           wr_en,
   input  logic [(BTB_SETS > 1 ? $clog2(BTB_SETS) : 1)-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]                            wr_data
);
   import btb_pkg::*;

   logic [ROW_BITS-1:0] mem [BTB_SETS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- bench/tb.sv -----
// Testbench for btb_bimodal_branch_predictor: directed table, then random predict/update
// beats checked against an in-bench model of the BTB, LRU order and direction counters.
// Depends on btb_pkg and the design sources.
module tb;
   import btb_pkg::*;

   localparam int Sets = 64;
   localparam int Ways = 4;
   localparam int Bht = 1024;
   localparam int Inst = 4;
   localparam int WatchLimit = 20000;

   typedef struct packed {
      logic       pred_taken;
      logic       btb_hit;
      logic [63:0] next_pc;
      logic [4:0] pred_slot;
   } rsp_t;

   typedef struct {
      action_type act;
      logic [63:0] pc;
      logic [3:0] slot;
      logic       taken;
      logic [63:0] target;
      logic       known;
      rsp_t       want;
   } beat_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [135:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic csr_wen = 0;
   logic [FwWidth-1:0] csr_wdata = '0;

   btb_bimodal_branch_predictor dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   logic [1:0]  ctr [Bht];
   logic        bvalid [Sets*Ways];
   logic [56:0] btag [Sets*Ways];
   logic [3:0]  bslot [Sets*Ways];
   logic [63:0] btarget [Sets*Ways];
   int          lru [Sets][Ways];
   logic [4:0]  fw;

   rsp_t pending_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   bit rand_stall = 1;

   function automatic void model_reset();
      for (int i = 0; i < Bht; i++) ctr[i] = CtrReset;
      for (int i = 0; i < Sets*Ways; i++) bvalid[i] = 0;
      for (int s = 0; s < Sets; s++)
         for (int w = 0; w < Ways; w++) lru[s][w] = w;
      fw = FetchWidthReset;
   endfunction

   function automatic void touch(int s, int w);
      int p;
      p = 0;
      while (p < Ways && lru[s][p] != w) p++;
      if (p >= Ways) p = Ways - 1;
      for (; p > 0; p--) lru[s][p] = lru[s][p-1];
      lru[s][0] = w;
   endfunction

   function automatic rsp_t predict_step(beat_t b);
      rsp_t r;
      int s, ci, way, e;
      logic [56:0] tg;
      logic [1:0] c;
      logic [63:0] resolved;
      bit hit;
      s = int'(b.pc[6:1]);
      tg = b.pc[63:7];
      ci = int'(b.pc[10:1]);
      way = -1;
      for (int w = Ways - 1; w >= 0; w--)
         if (bvalid[s*Ways+w] && btag[s*Ways+w] == tg) way = w;
      hit = (way >= 0);
      if (b.act == ACT_PREDICT) begin
         r.pred_taken = ctr[ci] >= 2;
         if (way < 0) begin
            r.pred_slot = fw;
            r.next_pc = b.pc + 64'(fw) * Inst;
            r.btb_hit = 0;
         end else begin
            e = s*Ways + way;
            r.pred_slot = {1'b0, bslot[e]};
            r.next_pc = r.pred_taken ? btarget[e] : b.pc + 64'(bslot[e]) + Inst;
            r.btb_hit = 1;
            touch(s, way);
         end
         return r;
      end
      c = ctr[ci];
      if (b.taken) c = (c == CtrMax) ? CtrMax : c + 2'd1;
      else c = (c == 2'd0) ? 2'd0 : c - 2'd1;
      ctr[ci] = c;
      resolved = b.taken ? b.target : b.pc + 64'(b.slot) + Inst;
      if (way >= 0) begin
         e = s*Ways + way;
         bslot[e] = b.slot;
         if (b.taken) btarget[e] = b.target;
         touch(s, way);
      end else begin
         way = lru[s][Ways-1];
         for (int w = Ways - 1; w >= 0; w--) if (!bvalid[s*Ways+w]) way = w;
         e = s*Ways + way;
         bvalid[e] = 1;
         btag[e] = tg;
         bslot[e] = b.slot;
         btarget[e] = resolved;
         touch(s, way);
      end
      r.pred_slot = {1'b0, b.slot};
      r.next_pc = resolved;
      r.btb_hit = hit;
      r.pred_taken = c >= 2;
      return r;
   endfunction

   function automatic int gap();
      if (!rand_stall) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   always @(posedge clock) begin
      rsp_t got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_t'(rsp_tdata[70:0]);
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            exp = pending_rsp.pop_front();
            if (got.pred_slot !== exp.pred_slot) begin
               $error("pred_slot exp %0d got %0d", exp.pred_slot, got.pred_slot); errors++;
            end
            if (got.next_pc !== exp.next_pc) begin
               $error("next_pc exp %h got %h", exp.next_pc, got.next_pc); errors++;
            end
            if (got.btb_hit !== exp.btb_hit) begin
               $error("btb_hit exp %0d got %0d", exp.btb_hit, got.btb_hit); errors++;
            end
            if (got.pred_taken !== exp.pred_taken) begin
               $error("pred_taken exp %0d got %0d", exp.pred_taken, got.pred_taken); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("btb_bimodal_branch_predictor: mismatch");
         $finish;
      end
   end

   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (n > 0) begin
            rsp_tready <= 0;
            n--;
         end else begin
            rsp_tready <= 1;
            if (rsp_tready) n = gap();
         end
      end
   end

   // valid stays up after a beat; the next call lowers it only if it waits a gap, a drain always does
   task automatic send(beat_t b);
      rsp_t r;
      int g;
      g = gap();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tdata <= {3'b0, b.target, b.taken, b.slot, b.pc};
      req_tuser <= b.act;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_step(b);
      if (b.known && r !== b.want) begin
         $error("table row disagrees with model: %h vs %h", b.want, r);
         errors++;
      end
      pending_rsp.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic drain_and_config(logic [4:0] v);
      drain();
      repeat (8) @(negedge clock);
      csr_wdata <= v;
      csr_wen <= 1;
      @(negedge clock);
      csr_wen <= 0;
      fw = v;
   endtask

   function automatic beat_t mk(action_type a, logic [63:0] pc, logic [3:0] sl,
                                logic tk, logic [63:0] tg);
      beat_t b;
      b.act = a; b.pc = pc; b.slot = sl; b.taken = tk; b.target = tg;
      b.known = 0; b.want = '0;
      return b;
   endfunction

   beat_t dir_tab[$];
   beat_t b;
   logic [63:0] hot_pcs[16];

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      b = mk(ACT_PREDICT, 64'h0, 0, 0, 0); b.known = 1;
      b.want = '{pred_taken: 0, btb_hit: 0, next_pc: 64'd32, pred_slot: 5'd8};
      dir_tab.push_back(b);
      b = mk(ACT_PREDICT, '1, 0, 0, 0); b.known = 1;
      b.want = '{pred_taken: 0, btb_hit: 0, next_pc: 64'd31, pred_slot: 5'd8};
      dir_tab.push_back(b);
      b = mk(ACT_UPDATE, 64'h1000, 4'hF, 1, 64'hDEAD_BEEF); b.known = 1;
      b.want = '{pred_taken: 1, btb_hit: 0, next_pc: 64'hDEAD_BEEF, pred_slot: 5'd15};
      dir_tab.push_back(b);
      dir_tab.push_back(mk(ACT_PREDICT, 64'h1000, 0, 0, 0));
      dir_tab.push_back(mk(ACT_UPDATE, 64'h1000, 4'h3, 0, '1));
      dir_tab.push_back(mk(ACT_UPDATE, 64'h1000, 4'h3, 0, '1));
      dir_tab.push_back(mk(ACT_PREDICT, 64'h1000, 0, 0, 0));
      dir_tab.push_back(mk(ACT_UPDATE, '1, 4'hF, 0, 0));
      dir_tab.push_back(mk(ACT_PREDICT, '1, 0, 0, 0));
      // six tags in one set: fill then LRU eviction
      for (int i = 0; i < 6; i++)
         dir_tab.push_back(mk(ACT_UPDATE, 64'h2000 + (64'(i) << 7), 4'(i), i[0], 64'(i)));
      for (int i = 0; i < 6; i++)
         dir_tab.push_back(mk(ACT_PREDICT, 64'h2000 + (64'(i) << 7), 0, 0, 0));
      dir_tab.push_back(mk(ACT_UPDATE, 64'h2000, 4'h0, 1, '1));
      foreach (dir_tab[i]) send(dir_tab[i]);

      foreach (hot_pcs[i]) hot_pcs[i] = {$urandom, $urandom} & 64'hFFFF_FFFF_FF07_07FE;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: drain_and_config(5'd1);
            1: drain_and_config(5'd16);
            2: drain_and_config(5'd0);
            3: drain_and_config(5'd31);
            default: drain_and_config(5'($urandom_range(1, 16)));
         endcase
         rand_stall = (ph != 2);
         for (int i = 0; i < 230; i++) begin
            logic [63:0] pc;
            case ($urandom_range(0, 9))
               0, 1: pc = {$urandom, $urandom};
               default: pc = hot_pcs[$urandom_range(0, 15)] ^
                             (64'($urandom_range(0, 3)) << 7);
            endcase
            b = mk(action_type'($urandom_range(0, 1)), pc, 4'($urandom),
                   1'($urandom), {$urandom, $urandom});
            send(b);
            if (ph == 3 && i == 100) drain();
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("btb_bimodal_branch_predictor: match");
      else
         $display("btb_bimodal_branch_predictor: mismatch");
      $finish;
   end
endmodule

// ----- files.f -----
design/btb_pkg.sv
design/btb_ctr_table.sv
design/btb_way_table.sv
design/btb_bimodal_branch_predictor.sv
bench/tb.sv
